[rtl/core/mmtkf_pkg.sv]
// ----------------------------------------------------------------------------
// mmtkf_pkg
// Shared constants and saturation function of the multi-mode tilt Kalman filter.
// ----------------------------------------------------------------------------
package mmtkf_pkg;

  localparam logic [31:0] NoiseAngleRst = 32'd16777;
  localparam logic [31:0] NoiseBiasRst  = 32'd11744051;
  localparam logic [31:0] MeasNoiseRst  = 32'd503316;

  localparam logic [1:0] ReqSample = 2'd0;
  localparam logic [1:0] ReqAngle  = 2'd1;
  localparam logic [1:0] ReqRef    = 2'd2;

  localparam logic [1:0] CfgNoiseAngle = 2'd0;
  localparam logic [1:0] CfgNoiseBias  = 2'd1;
  localparam logic [1:0] CfgMeasNoise  = 2'd2;

  localparam logic [1:0] ModeAcc    = 2'd0;
  localparam logic [1:0] ModeStatic = 2'd1;
  localparam logic [1:0] ModeRot    = 2'd2;

  localparam logic signed [33:0] ThSettle = 34'sd983;
  localparam logic signed [33:0] ThAcc    = 34'sd4588;
  localparam logic signed [33:0] ThRateLo = -34'sd72090;
  localparam logic signed [33:0] ThRateHi = 34'sd65536;
  localparam logic signed [33:0] ThBiasLo = -34'sd91750;
  localparam logic signed [33:0] ThBiasHi = 34'sd78643;

  localparam logic [7:0] SettleEnter = 8'd5;
  localparam logic [7:0] SettleForce = 8'd8;
  localparam logic [7:0] DriftEnter  = 8'd3;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

[rtl/core/mmtkf_div.sv]
// ----------------------------------------------------------------------------
// mmtkf_div
// Radix-2 signed divider: sat32((num << 24) / den), truncating, zero on den 0.
// ----------------------------------------------------------------------------
module mmtkf_div
  import mmtkf_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [31:0]       num_i,
  input  logic signed [33:0]       den_i,
  output logic                     done_o,
  output logic signed [31:0]       quo_o
);

  localparam int unsigned NumW = 56;

  logic [NumW-1:0] n_q, n_d;
  logic [33:0]     d_q, d_d;
  logic [34:0]     r_q, r_d;
  logic [5:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            neg_q, neg_d;
  logic            zero_q, zero_d;
  logic            done_q, done_d;
  logic signed [31:0] quo_q, quo_d;
  logic [34:0]     rs;
  logic signed [66:0] qs;

  always_comb begin
    n_d = n_q;
    d_d = d_q;
    r_d = r_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    neg_d = neg_q;
    zero_d = zero_q;
    done_d = 1'b0;
    quo_d = quo_q;
    rs = {r_q[33:0], n_q[NumW-1]};
    qs = '0;
    if (start_i) begin
      n_d = {(num_i[31] ? 32'(-num_i) : 32'(num_i)), 24'd0};
      d_d = den_i[33] ? 34'(-den_i) : 34'(den_i);
      r_d = '0;
      cnt_d = 6'(NumW);
      busy_d = 1'b1;
      neg_d = num_i[31] ^ den_i[33];
      zero_d = (den_i == '0);
    end else if (busy_q) begin
      if (rs >= {1'b0, d_q}) begin
        r_d = rs - {1'b0, d_q};
        n_d = {n_q[NumW-2:0], 1'b1};
      end else begin
        r_d = rs;
        n_d = {n_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        qs = neg_q ? -$signed({11'd0, n_d}) : $signed({11'd0, n_d});
        quo_d = zero_q ? '0 : sat32(qs[65:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    d_q <= d_d;
    r_q <= r_d;
    neg_q <= neg_d;
    zero_q <= zero_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o = quo_q;

endmodule

[rtl/core/multi_mode_tilt_kalman_filter.sv]
// ----------------------------------------------------------------------------
// multi_mode_tilt_kalman_filter
// Two-state angle/bias tilt Kalman filter with motion mode classification.
// ----------------------------------------------------------------------------
// A sample item walks the states StMode, StPred, StCovT, StCovP0, StCovP3,
// StDiv0, StDiv1, StBias, StAngle and StP2 to StP1 before its result shows;
// StRotRef is added when rotation mode continues and StRotEnt and StRotRef
// when it is entered. One shared 32x35 multiplier does one product of the
// update per cycle, and a radix-2 divider computes each of the two gains. A
// preset item shows its result in the next cycle. The block takes no new item
// until the result has been taken.
module multi_mode_tilt_kalman_filter
  import mmtkf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] acc_angle_i,
  input  logic signed [31:0] gyro_rate_i,
  input  logic [15:0]        time_step_i,
  input  logic signed [31:0] preset_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] angle_estimate_o,
  output logic signed [31:0] bias_estimate_o,
  output logic signed [31:0] reference_angle_out_o,
  output logic [1:0]         motion_mode_o
);

  typedef enum logic [16:0] {
    StIdle   = 17'b00000000000000001,
    StMode   = 17'b00000000000000010,
    StRotEnt = 17'b00000000000000100,
    StRotRef = 17'b00000000000001000,
    StPred   = 17'b00000000000010000,
    StCovT   = 17'b00000000000100000,
    StCovP0  = 17'b00000000001000000,
    StCovP3  = 17'b00000000010000000,
    StDiv0   = 17'b00000000100000000,
    StDiv1   = 17'b00000001000000000,
    StBias   = 17'b00000010000000000,
    StAngle  = 17'b00000100000000000,
    StP2     = 17'b00001000000000000,
    StP3     = 17'b00010000000000000,
    StP0     = 17'b00100000000000000,
    StP1     = 17'b01000000000000000,
    StOut    = 17'b10000000000000000
  } state_e;

  state_e st_q, st_d;

  logic [31:0] na_q, nb_q, nm_q;
  logic signed [31:0] ang_q, bias_q, ref_q, pacc_q, drs_q, res_q;
  logic signed [31:0] p0_q, p1_q, p2_q, p3_q;
  logic [1:0] pmode_q, mode_q, omode_q;
  logic [7:0] settle_q, drift_q;
  logic signed [31:0] acc_q, rate_q;
  logic [15:0] dt_q;
  logic signed [31:0] rab_q, pred_q, inn_q, k0_q, k1_q;
  logic signed [34:0] t_q;

  // shared multiplier
  logic signed [31:0] ma;
  logic signed [34:0] mb;
  logic               msh24;
  logic signed [66:0] mp;
  logic signed [65:0] mr;
  always_comb begin
    mp = ma * mb;
    if (msh24) mr = 66'((mp + 67'sd8388608) >>> 24);
    else mr = 66'((mp + 67'sd32768) >>> 16);
  end

  logic div_start, div_done;
  logic signed [31:0] div_num, div_q;
  logic signed [33:0] div_den;
  mmtkf_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_q)
  );
  assign div_den = 34'(p0_q) + 34'(nm_q);

  // mode classification
  logic signed [33:0] sd, ad, rt;
  logic [7:0] set_n, dr_n;
  logic [1:0] md;
  logic signed [31:0] drs_n, res_n;
  logic dr_hit;
  always_comb begin
    sd = 34'(acc_q) - 34'(pacc_q);
    ad = 34'(acc_q) - 34'(ang_q);
    rt = 34'(rate_q);
    set_n = (sd > -ThSettle && sd < ThSettle) ?
            ((settle_q != 8'hff) ? settle_q + 8'd1 : settle_q) : 8'd0;
    md = ModeAcc;
    if (ad > -ThAcc && ad < ThAcc && rt > ThRateLo && rt < ThRateHi &&
        set_n >= SettleEnter) md = ModeStatic;
    if (pmode_q != ModeStatic && set_n >= SettleForce) md = ModeStatic;
    if (pmode_q == ModeStatic && set_n != 8'd0) md = ModeStatic;
    dr_hit = rt <= ThRateLo || rt >= ThRateHi;
    dr_n = dr_hit ? ((drift_q != 8'hff) ? drift_q + 8'd1 : drift_q) : 8'd0;
    drs_n = dr_hit ? sat32(66'(drs_q) + 66'(rate_q)) : '0;
    res_n = res_q;
    if (dr_n != 8'd0 && pmode_q == ModeRot) begin
      md = ModeRot;
      dr_n = '0;
      drs_n = '0;
    end
    if (dr_n >= DriftEnter && pmode_q != ModeRot) begin
      md = ModeRot;
      dr_n = '0;
      res_n = drs_n;
      drs_n = '0;
    end
  end

  // multiply step operands
  always_comb begin
    ma = 32'(dt_q);
    mb = 35'(rate_q);
    msh24 = 1'b0;
    unique case (st_q)
      StRotEnt: mb = 35'(sat32(66'(res_q) - 66'(rate_q)));
      StPred:   mb = 35'(rab_q);
      StCovT:   mb = 35'(p3_q);
      StCovP0:  mb = t_q;
      StCovP3:  mb = 35'(nb_q);
      StBias:   begin ma = k1_q; mb = 35'(inn_q); msh24 = 1'b1; end
      StAngle:  begin ma = k0_q; mb = 35'(inn_q); msh24 = 1'b1; end
      StP2:     begin ma = k1_q; mb = 35'(p0_q); msh24 = 1'b1; end
      StP3:     begin ma = k1_q; mb = 35'(p1_q); msh24 = 1'b1; end
      StP0:     begin ma = k0_q; mb = 35'(p0_q); msh24 = 1'b1; end
      StP1:     begin ma = k0_q; mb = 35'(p1_q); msh24 = 1'b1; end
      default: ;
    endcase
  end

  logic signed [31:0] bias_inc;
  assign bias_inc = sat32(66'(bias_q) + mr);

  assign div_start = (st_q == StCovP3) || (st_q == StDiv0 && div_done);
  assign div_num = (st_q == StDiv0) ? p2_q : p0_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (in_valid_i) st_d = (req_type_i == ReqSample) ? StMode : StOut;
      StMode: begin
        if (md != ModeRot) st_d = StPred;
        else if (pmode_q != ModeRot) st_d = StRotEnt;
        else st_d = StRotRef;
      end
      StRotEnt: st_d = StRotRef;
      StRotRef: st_d = StPred;
      StPred:   st_d = StCovT;
      StCovT:   st_d = StCovP0;
      StCovP0:  st_d = StCovP3;
      StCovP3:  st_d = StDiv0;
      StDiv0:   if (div_done) st_d = StDiv1;
      StDiv1:   if (div_done) st_d = StBias;
      StBias:   st_d = StAngle;
      StAngle:  st_d = StP2;
      StP2:     st_d = StP3;
      StP3:     st_d = StP0;
      StP0:     st_d = StP1;
      StP1:     st_d = StOut;
      StOut:    if (out_ready_i) st_d = StIdle;
      default:  st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      na_q <= NoiseAngleRst;
      nb_q <= NoiseBiasRst;
      nm_q <= MeasNoiseRst;
      ang_q <= '0; bias_q <= '0; ref_q <= '0; pacc_q <= '0;
      p0_q <= '0; p1_q <= '0; p2_q <= '0; p3_q <= '0;
      pmode_q <= ModeAcc; settle_q <= '0; drift_q <= '0;
      drs_q <= '0; res_q <= '0; omode_q <= ModeAcc;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgNoiseAngle: na_q <= cfg_data_i;
          CfgNoiseBias:  nb_q <= cfg_data_i;
          CfgMeasNoise:  nm_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (st_q)
        StIdle: if (in_valid_i) begin
          omode_q <= pmode_q;
          if (req_type_i == ReqAngle) ang_q <= preset_value_i;
          if (req_type_i == ReqRef) begin
            ref_q <= preset_value_i;
            pacc_q <= preset_value_i;
          end
        end
        StMode: begin
          settle_q <= set_n; drift_q <= dr_n; drs_q <= drs_n; res_q <= res_n;
          if (md == ModeStatic &&
              (pmode_q != ModeStatic || (ad > -ThSettle && ad < ThSettle)))
            ref_q <= acc_q;
          pmode_q <= md; omode_q <= md; pacc_q <= acc_q;
        end
        StRotEnt: ang_q <= sat32(66'(ang_q) + mr);
        StRotRef: ref_q <= sat32(66'(ang_q) + mr);
        StPred: begin
          if (mode_q == ModeAcc && (34'(rab_q) < ThBiasLo || 34'(rab_q) > ThBiasHi))
            ref_q <= sat32(66'(ref_q) + mr);
        end
        StCovT: begin
          p1_q <= sat32(66'(p1_q) - mr);
          p2_q <= sat32(66'(p2_q) - mr);
        end
        StCovP0: p0_q <= sat32(66'(p0_q) + mr);
        StCovP3: p3_q <= sat32(66'(p3_q) + mr);
        StBias:  bias_q <= (mode_q == ModeStatic) ? sat32(66'(bias_inc) + mr) : bias_inc;
        StAngle: ang_q <= sat32(66'(pred_q) + mr);
        StP2:    p2_q <= sat32(66'(p2_q) - mr);
        StP3:    p3_q <= sat32(66'(p3_q) - mr);
        StP0:    p0_q <= sat32(66'(p0_q) - mr);
        StP1:    p1_q <= sat32(66'(p1_q) - mr);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && in_valid_i) begin
      acc_q <= acc_angle_i; rate_q <= gyro_rate_i; dt_q <= time_step_i;
    end
    if (st_q == StMode) begin
      mode_q <= md;
      rab_q <= sat32(66'(rate_q) - 66'(bias_q));
    end
    if (st_q == StPred) pred_q <= sat32(66'(ang_q) + mr);
    if (st_q == StCovT) begin
      inn_q <= sat32(66'(ref_q) - 66'(pred_q));
      t_q <= 35'(mr) - 35'(p1_q) - 35'(p2_q) + 35'(na_q);
    end
    if (st_q == StDiv0 && div_done) k0_q <= div_q;
    if (st_q == StDiv1 && div_done) k1_q <= div_q;
  end

  assign in_ready_o = (st_q == StIdle);
  assign out_valid_o = (st_q == StOut);
  assign angle_estimate_o = ang_q;
  assign bias_estimate_o = bias_q;
  assign reference_angle_out_o = ref_q;
  assign motion_mode_o = omode_q;

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the multi-mode tilt Kalman filter. Items go in through a
// valid/ready channel in random bursts. Each accepted item runs through a
// bit-exact predictor of the mode classifier and the angle/bias update. Each
// result is compared field by field with the oldest prediction, while the
// receiver stalls on its own pattern. The noise registers are swept over
// defaults, zero, all ones and random values between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import mmtkf_pkg::*;

  localparam int unsigned CycleLimit = 1000000;

  typedef struct packed {
    logic signed [31:0] angle;
    logic signed [31:0] bias;
    logic signed [31:0] ref_angle;
    logic [1:0]         mode;
  } estimate_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [31:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         req_type_i;
  logic signed [31:0] acc_angle_i;
  logic signed [31:0] gyro_rate_i;
  logic [15:0]        time_step_i;
  logic signed [31:0] preset_value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] angle_estimate_o;
  logic signed [31:0] bias_estimate_o;
  logic signed [31:0] reference_angle_out_o;
  logic [1:0]         motion_mode_o;

  multi_mode_tilt_kalman_filter u_top (.*);

  // filter state mirror
  longint noise_angle, noise_bias, meas_noise;
  longint f_angle, f_bias, f_ref, f_prev_acc, f_drift_sum, f_rot_sum;
  longint cov [4];
  logic [1:0] f_prev_mode;
  int unsigned f_settle, f_drift;

  estimate_t   estimate_q [$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned stall_phase;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_mul(longint a, longint b, int n);
    longint p;
    p = a * b + (64'sd1 <<< (n - 1));
    return p >>> n;
  endfunction

  function automatic longint kalman_gain(longint num, longint den);
    if (den == 0) return 0;
    return clamp32((num * (64'sd1 <<< 24)) / den);
  endfunction

  task automatic reset_filter_model();
    noise_angle = NoiseAngleRst;
    noise_bias  = NoiseBiasRst;
    meas_noise  = MeasNoiseRst;
    f_angle = 0; f_bias = 0; f_ref = 0; f_prev_acc = 0;
    f_drift_sum = 0; f_rot_sum = 0;
    foreach (cov[i]) cov[i] = 0;
    f_prev_mode = ModeAcc;
    f_settle = 0;
    f_drift = 0;
  endtask

  function automatic estimate_t filter_step(logic [1:0] req, logic signed [31:0] acc_in,
                                            logic signed [31:0] rate_in, logic [15:0] dt_in,
                                            logic signed [31:0] preset);
    estimate_t r;
    longint acc, rate, dt, acc_diff, still_diff, rab, pred, innov, k0, k1, p00, p01, s, t;
    logic [1:0] mode, old;
    mode = f_prev_mode;
    if (req == ReqAngle) begin
      f_angle = preset;
    end else if (req == ReqRef) begin
      f_ref = preset;
      f_prev_acc = preset;
    end else if (req == ReqSample) begin
      acc = acc_in;
      rate = rate_in;
      dt = {48'd0, dt_in};
      acc_diff = acc - f_angle;
      still_diff = acc - f_prev_acc;
      old = f_prev_mode;
      mode = ModeAcc;
      if (still_diff > -ThSettle && still_diff < ThSettle) begin
        if (f_settle < 255) f_settle++;
      end else begin
        f_settle = 0;
      end
      if (acc_diff > -ThAcc && acc_diff < ThAcc && rate > ThRateLo && rate < ThRateHi &&
          f_settle >= SettleEnter)
        mode = ModeStatic;
      if (old != ModeStatic && f_settle >= SettleForce) mode = ModeStatic;
      if (old == ModeStatic && f_settle > 0) mode = ModeStatic;
      if (rate <= ThRateLo || rate >= ThRateHi) begin
        if (f_drift < 255) f_drift++;
        f_drift_sum = clamp32(f_drift_sum + rate);
      end else begin
        f_drift = 0;
        f_drift_sum = 0;
      end
      if (f_drift > 0 && old == ModeRot) begin
        mode = ModeRot;
        f_drift = 0;
        f_drift_sum = 0;
      end
      if (f_drift >= DriftEnter && old != ModeRot) begin
        mode = ModeRot;
        f_drift = 0;
        f_rot_sum = f_drift_sum;
        f_drift_sum = 0;
      end
      if (mode == ModeStatic) begin
        if (old != ModeStatic) f_ref = acc;
        if (acc_diff > -ThSettle && acc_diff < ThSettle) f_ref = acc;
      end else if (mode == ModeRot) begin
        if (old != ModeRot)
          f_angle = clamp32(f_angle + round_mul(dt, clamp32(f_rot_sum - rate), 16));
        f_ref = clamp32(f_angle + round_mul(dt, rate, 16));
      end
      rab = clamp32(rate - f_bias);
      if (mode == ModeAcc && (rab < ThBiasLo || rab > ThBiasHi))
        f_ref = clamp32(f_ref + round_mul(dt, rab, 16));
      pred = clamp32(f_angle + round_mul(dt, rab, 16));
      innov = clamp32(f_ref - pred);

      t = round_mul(dt, cov[3], 16) - cov[1] - cov[2] + noise_angle;
      cov[0] = clamp32(cov[0] + round_mul(dt, t, 16));
      t = round_mul(dt, cov[3], 16);
      cov[1] = clamp32(cov[1] - t);
      cov[2] = clamp32(cov[2] - t);
      cov[3] = clamp32(cov[3] + round_mul(noise_bias, dt, 16));

      s = cov[0] + meas_noise;
      k0 = kalman_gain(cov[0], s);
      k1 = kalman_gain(cov[2], s);
      if (mode == ModeStatic) f_bias = clamp32(f_bias + round_mul(k1, innov, 24));
      f_angle = clamp32(pred + round_mul(k0, innov, 24));
      f_bias = clamp32(f_bias + round_mul(k1, innov, 24));

      p00 = cov[0];
      p01 = cov[1];
      cov[0] = clamp32(cov[0] - round_mul(k0, p00, 24));
      cov[1] = clamp32(cov[1] - round_mul(k0, p01, 24));
      cov[2] = clamp32(cov[2] - round_mul(k1, p00, 24));
      cov[3] = clamp32(cov[3] - round_mul(k1, p01, 24));
      f_prev_mode = mode;
      f_prev_acc = acc;
    end
    r.angle = f_angle[31:0];
    r.bias = f_bias[31:0];
    r.ref_angle = f_ref[31:0];
    r.mode = mode;
    return r;
  endfunction

  task automatic send_item(logic [1:0] req, logic signed [31:0] acc, logic signed [31:0] rate,
                           logic [15:0] dt, logic signed [31:0] preset);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    acc_angle_i    <= acc;
    gyro_rate_i    <= rate;
    time_step_i    <= dt;
    preset_value_i <= preset;
    do @(posedge clk_i); while (!in_ready_o);
    estimate_q.push_back(filter_step(req, acc, rate, dt, preset));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (estimate_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_noise(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgNoiseAngle) noise_angle = {32'd0, val};
    else if (idx == CfgNoiseBias) noise_bias = {32'd0, val};
    else if (idx == CfgMeasNoise) meas_noise = {32'd0, val};
  endtask

  task automatic set_noise(logic [31:0] qa, logic [31:0] qb, logic [31:0] rm);
    drain();
    write_noise(CfgNoiseAngle, qa);
    write_noise(CfgNoiseBias, qb);
    write_noise(CfgMeasNoise, rm);
  endtask

  function automatic logic signed [31:0] rand_angle();
    return $signed($urandom_range(0, 23592960)) - 32'sd11796480;
  endfunction

  function automatic logic signed [31:0] rand_rate(bit fast);
    logic signed [31:0] m;
    if (fast) m = $urandom_range(65536, 9000000);
    else m = $urandom_range(0, 72089);
    if (fast && $urandom_range(0, 1)) return -m;
    if (!fast) return m - 32'sd65535;
    return m;
  endfunction

  function automatic logic [15:0] rand_dt();
    case ($urandom_range(0, 7))
      0: return 16'($urandom());
      1: return 16'hffff;
      default: return 16'($urandom_range(1, 3000));
    endcase
  endfunction

  task automatic test_presets();
    send_item(ReqSample, 0, 0, 0, 0);
    send_item(ReqAngle, 0, 0, 0, 32'sh7fffffff);
    send_item(ReqRef, 0, 0, 0, 32'sh80000000);
    send_item(2'd3, -1, -1, 16'hffff, -1);
    send_item(ReqAngle, 0, 0, 0, 0);
    send_item(ReqRef, 0, 0, 0, 0);
  endtask

  task automatic test_field_extremes();
    send_item(ReqSample, 32'sh7fffffff, 32'sh7fffffff, 16'hffff, 0);
    send_item(ReqSample, 32'sh80000000, 32'sh80000000, 16'hffff, 0);
    send_item(ReqSample, 32'sh80000000, 32'sh7fffffff, 16'h0000, 0);
    send_item(ReqSample, 32'sh7fffffff, 32'sh80000000, 16'h0001, -1);
  endtask

  task automatic test_zero_variance();
    set_noise(32'd0, 32'd0, 32'd0);
    send_item(ReqSample, 32'sd65536, 32'sd0, 16'd0, 0);
    send_item(ReqSample, 32'sd65536, 32'sd100, 16'd0, 0);
    set_noise(NoiseAngleRst, NoiseBiasRst, MeasNoiseRst);
  endtask

  task automatic test_mode_entry();
    send_item(ReqRef, 0, 0, 0, 32'sd655360);
    send_item(ReqAngle, 0, 0, 0, 32'sd655360);
    repeat (10) send_item(ReqSample, 32'sd655360 + $signed($urandom_range(0, 800)) - 400,
                          $signed($urandom_range(0, 2000)) - 1000, 16'd655, 0);
    repeat (5) send_item(ReqSample, rand_angle(), 32'sd3276800, 16'd655, 0);
  endtask

  task automatic test_random_phase(int unsigned count);
    int unsigned sent, len, kind;
    logic signed [31:0] base;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        base = rand_angle();
        if ($urandom_range(0, 1)) begin
          send_item(ReqRef, 0, 0, 0, base);
          send_item(ReqAngle, 0, 0, 0, base + $signed($urandom_range(0, 6000)) - 3000);
          sent += 2;
        end
        len = $urandom_range(4, 14);
        repeat (len) send_item(ReqSample, base + $signed($urandom_range(0, 1400)) - 700,
                               $urandom_range(0, 9) == 0 ? rand_rate(1) : rand_rate(0),
                               rand_dt(), $urandom());
        sent += len;
      end else if (kind <= 5) begin
        len = $urandom_range(2, 8);
        repeat (len) send_item(ReqSample, rand_angle(),
                               $urandom_range(0, 5) == 0 ? rand_rate(0) : rand_rate(1),
                               rand_dt(), $urandom());
        sent += len;
      end else if (kind == 6) begin
        send_item(2'($urandom_range(1, 3)), $urandom(), $urandom(), 16'($urandom()),
                  $urandom());
        sent++;
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) send_item(ReqSample, $urandom_range(0, 1) ? $urandom() : rand_angle(),
                               $urandom_range(0, 1) ? $urandom() : rand_rate(0),
                               16'($urandom()), $urandom());
        sent += len;
      end
    end
  endtask

  task automatic test_noise_sweep();
    test_random_phase(280);
    set_noise(32'hffffffff, 32'hffffffff, 32'hffffffff);
    test_random_phase(280);
    set_noise($urandom(), $urandom(), $urandom());
    test_random_phase(280);
    set_noise($urandom_range(0, 4000), $urandom_range(0, 4000000), $urandom_range(1, 900));
    test_random_phase(280);
    set_noise(NoiseAngleRst, NoiseBiasRst, MeasNoiseRst);
    test_random_phase(280);
  endtask

  // receiver stall pattern
  always @(negedge clk_i) begin
    stall_phase <= stall_phase + 1;
    case (stall_phase[9:8])
      2'd0: out_ready_i <= 1'b1;
      2'd1: out_ready_i <= $urandom_range(0, 1);
      2'd2: out_ready_i <= (stall_phase[2:0] == 3'd0);
      default: out_ready_i <= $urandom_range(0, 7) != 0;
    endcase
  end

  always @(posedge clk_i) begin
    estimate_t e;
    if (out_valid_o && out_ready_i) begin
      if (estimate_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result at cycle %0d", cycle_count);
      end else begin
        e = estimate_q.pop_front();
        if (angle_estimate_o !== e.angle || bias_estimate_o !== e.bias ||
            reference_angle_out_o !== e.ref_angle || motion_mode_o !== e.mode) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: angle %0d/%0d bias %0d/%0d ref %0d/%0d mode %0d/%0d (exp/act)",
                     e.angle, angle_estimate_o, e.bias, bias_estimate_o,
                     e.ref_angle, reference_angle_out_o, e.mode, motion_mode_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgNoiseAngle;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    req_type_i = ReqSample;
    acc_angle_i = '0;
    gyro_rate_i = '0;
    time_step_i = '0;
    preset_value_i = '0;
    out_ready_i = 1'b1;
    stall_phase = 0;
    mismatch_count = 0;
    cycle_count = 0;
    burst_left = 0;
    reset_filter_model();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    test_presets();
    test_field_extremes();
    test_zero_variance();
    test_mode_entry();
    test_noise_sweep();
    drain();
    repeat (200) @(negedge clk_i);
    if (mismatch_count == 0 && estimate_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
